### rtl/core/bxlr_pkg.sv
// bxlr_pkg: types, class codes and helper functions for the explicit level resolver
// no dependencies; imported by every module of the resolver
`timescale 1ns / 1ps

package bxlr_pkg;

    // nesting limit and derived widths
    localparam int MAX_NESTING = 125;
    localparam int NUM_CELLS   = MAX_NESTING;
    localparam int DEPTH_W     = $clog2(MAX_NESTING + 1);
    localparam int LEVEL_W     = 8;
    localparam int CLASS_W     = 5;
    localparam int CNT_W       = 16;

    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    // bidirectional class codes
    localparam logic [CLASS_W-1:0] CLS_L   = 5'd0;
    localparam logic [CLASS_W-1:0] CLS_R   = 5'd1;
    localparam logic [CLASS_W-1:0] CLS_BN  = 5'd9;
    localparam logic [CLASS_W-1:0] CLS_B   = 5'd10;
    localparam logic [CLASS_W-1:0] CLS_LRE = 5'd14;
    localparam logic [CLASS_W-1:0] CLS_LRO = 5'd15;
    localparam logic [CLASS_W-1:0] CLS_RLE = 5'd16;
    localparam logic [CLASS_W-1:0] CLS_RLO = 5'd17;
    localparam logic [CLASS_W-1:0] CLS_PDF = 5'd18;
    localparam logic [CLASS_W-1:0] CLS_LRI = 5'd19;
    localparam logic [CLASS_W-1:0] CLS_RLI = 5'd20;
    localparam logic [CLASS_W-1:0] CLS_FSI = 5'd21;
    localparam logic [CLASS_W-1:0] CLS_PDI = 5'd22;

    // directional override of a stack entry
    typedef enum logic [1:0] {
        OVR_NONE,
        OVR_L,
        OVR_R
    } ovr_t;

    // one directional status entry
    typedef struct packed {
        logic [LEVEL_W-1:0] level;
        ovr_t               ovr;
        logic               iso;
    } entry_t;

    // shift control seen by every cell
    typedef struct packed {
        logic push;
        logic pop;
    } shift_ctl_t;

    // stack control from the sequencer
    typedef struct packed {
        logic push;
        logic pop;
        logic clear;
    } stk_ctl_t;

    // one result
    typedef struct packed {
        logic [LEVEL_W-1:0] level;
        logic [CLASS_W-1:0] cls;
    } res_t;

    // sequencer states
    typedef enum logic [1:0] {
        S_IDLE,
        S_UNWIND,
        S_EMIT
    } state_t;

    // next odd or next even level above lv
    function automatic logic [LEVEL_W-1:0] next_level(input logic [LEVEL_W-1:0] lv,
                                                      input logic odd);
        logic [LEVEL_W-1:0] r;
        if (odd)
        begin
            r = lv[0] ? lv + LEVEL_W'(2) : lv + LEVEL_W'(1);
        end
        else
        begin
            r = lv[0] ? lv + LEVEL_W'(1) : lv + LEVEL_W'(2);
        end
        return r;
    endfunction

    // class rewrite under an active override
    function automatic logic [CLASS_W-1:0] apply_override(input ovr_t ovr,
                                                          input logic [CLASS_W-1:0] cls);
        logic [CLASS_W-1:0] r;
        case (ovr)
            OVR_L:   r = CLS_L;
            OVR_R:   r = CLS_R;
            default: r = cls;
        endcase
        return r;
    endfunction

endpackage

### rtl/core/bxlr_cell.sv
// bxlr_cell: one directional status stack cell, shifts with its neighbors
// depends on bxlr_pkg
`timescale 1ns / 1ps

module bxlr_cell (
    input  logic                clk,
    input  bxlr_pkg::shift_ctl_t ctl,
    input  bxlr_pkg::entry_t    above,
    input  bxlr_pkg::entry_t    below,
    output bxlr_pkg::entry_t    q
);
    import bxlr_pkg::*;

    entry_t entry_reg;
    entry_t entry_next;

    // push takes the neighbor nearer the top, pop the one farther down
    always_comb
    begin
        entry_next = entry_reg;
        if (ctl.push)
        begin
            entry_next = above;
        end
        else if (ctl.pop)
        begin
            entry_next = below;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign q = entry_reg;

endmodule

### rtl/core/bxlr_stack.sv
// bxlr_stack: directional status stack as a row of shifting cells plus a depth counter
// depends on bxlr_pkg and bxlr_cell
`timescale 1ns / 1ps

module bxlr_stack (
    input  logic                          clk,
    input  logic                          rst_n,
    input  bxlr_pkg::stk_ctl_t            ctl,
    input  bxlr_pkg::entry_t              push_entry,
    output bxlr_pkg::entry_t              top_entry,
    output bxlr_pkg::entry_t              next_entry,
    output logic [bxlr_pkg::DEPTH_W-1:0]  depth
);
    import bxlr_pkg::*;

    logic [DEPTH_W-1:0] depth_reg;
    logic [DEPTH_W-1:0] depth_next;
    shift_ctl_t         shift_ctl;
    entry_t             cell_q  [NUM_CELLS];
    entry_t             above_d [NUM_CELLS];
    entry_t             below_d [NUM_CELLS];

    // a pop on an empty stack moves nothing
    assign shift_ctl.push = ctl.push;
    assign shift_ctl.pop  = ctl.pop && (depth_reg != '0);

    // depth counter
    always_comb
    begin
        depth_next = depth_reg;
        if (ctl.clear)
        begin
            depth_next = '0;
        end
        else if (shift_ctl.push)
        begin
            depth_next = depth_reg + DEPTH_W'(1);
        end
        else if (shift_ctl.pop)
        begin
            depth_next = depth_reg - DEPTH_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            depth_reg <= '0;
        end
        else
        begin
            depth_reg <= depth_next;
        end
    end

    // row of cells, cell zero holds the top entry
    for (genvar k = 0; k < NUM_CELLS; k++)
    begin : g_cell
        if (k == 0)
        begin : g_head
            assign above_d[k] = push_entry;
        end
        else
        begin : g_mid
            assign above_d[k] = cell_q[k-1];
        end

        if (k == NUM_CELLS - 1)
        begin : g_tail
            assign below_d[k] = '0;
        end
        else
        begin : g_link
            assign below_d[k] = cell_q[k+1];
        end

        bxlr_cell u_cell (
            .clk   (clk),
            .ctl   (shift_ctl),
            .above (above_d[k]),
            .below (below_d[k]),
            .q     (cell_q[k])
        );
    end

    assign top_entry = cell_q[0];

    if (NUM_CELLS > 1)
    begin : g_next
        assign next_entry = cell_q[1];
    end
    else
    begin : g_no_next
        assign next_entry = '0;
    end

    assign depth = depth_reg;

    // checks
    a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
        depth_reg <= DEPTH_W'(MAX_NESTING))
        else $error("stack depth beyond nesting limit");

    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.push |-> (depth_reg != DEPTH_W'(MAX_NESTING)))
        else $error("push on a full stack");

endmodule

### rtl/core/bxlr_outq.sv
// bxlr_outq: two-slot result queue, output register plus skid slot
// depends on bxlr_pkg
`timescale 1ns / 1ps

module bxlr_outq (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          load,
    input  bxlr_pkg::res_t                load_res,
    output logic                          full,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [bxlr_pkg::LEVEL_W-1:0]  level,
    output logic [bxlr_pkg::CLASS_W-1:0]  resolved_class
);
    import bxlr_pkg::*;

    logic out_valid_reg;
    logic out_valid_next;
    logic skid_valid_reg;
    logic skid_valid_next;
    res_t out_res_reg;
    res_t out_res_next;
    res_t skid_res_reg;
    res_t skid_res_next;
    logic take;

    assign take = out_valid_reg && out_ready;

    // slot update
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_res_next    = out_res_reg;
        skid_res_next   = skid_res_reg;
        if (take)
        begin
            if (skid_valid_reg)
            begin
                out_res_next    = skid_res_reg;
                skid_valid_next = load;
                skid_res_next   = load ? load_res : skid_res_reg;
            end
            else
            begin
                out_valid_next = load;
                out_res_next   = load ? load_res : out_res_reg;
            end
        end
        else if (!out_valid_reg)
        begin
            out_valid_next = load;
            out_res_next   = load ? load_res : out_res_reg;
        end
        else if (load)
        begin
            skid_valid_next = 1'b1;
            skid_res_next   = load_res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_res_reg  <= out_res_next;
        skid_res_reg <= skid_res_next;
    end

    assign full           = skid_valid_reg;
    assign out_valid      = out_valid_reg;
    assign level          = out_res_reg.level;
    assign resolved_class = out_res_reg.cls;

endmodule

### rtl/core/bidi_explicit_level_resolver.sv
// bidi_explicit_level_resolver: explicit embedding levels (rules X1 to X9), top level
// depends on bxlr_pkg, bxlr_stack, bxlr_outq
//
//   channel   signals                                      direction
//   in        in_valid in_ready bidi_class fsi_is_rtl      request in
//             last_of_paragraph
//   out       out_valid out_ready level resolved_class     request out
//   cfg       cfg_we cfg_wdata (base_level)                write in
//
// A PDI that closes a valid isolate unwinds first: the cell row shifts up one entry
// per cycle, removing every entry above the isolate entry and then that entry itself;
// then the result is queued. Other requests are resolved as they are taken.
// Reset is immediate: the stack depth and counters clear, no clearing pass.
// A two-slot result queue lets a request be taken while one result waits;
// input stalls while a PDI unwinds or emits and while both slots are full.
`timescale 1ns / 1ps

module bidi_explicit_level_resolver (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [bxlr_pkg::CLASS_W-1:0]  bidi_class,
    input  logic                          fsi_is_rtl,
    input  logic                          last_of_paragraph,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [bxlr_pkg::LEVEL_W-1:0]  level,
    output logic [bxlr_pkg::CLASS_W-1:0]  resolved_class,
    input  logic                          cfg_we,
    input  logic                          cfg_wdata
);
    import bxlr_pkg::*;

    state_t             state_reg;
    state_t             state_next;
    logic               base_level_reg;
    logic [CNT_W-1:0]   ovf_iso_reg;
    logic [CNT_W-1:0]   ovf_iso_next;
    logic [CNT_W-1:0]   ovf_emb_reg;
    logic [CNT_W-1:0]   ovf_emb_next;
    logic [DEPTH_W-1:0] valid_iso_reg;
    logic [DEPTH_W-1:0] valid_iso_next;
    logic               last_hold_reg;
    logic               last_hold_next;

    stk_ctl_t           stk_ctl;
    entry_t             push_entry;
    entry_t             top_entry;
    entry_t             next_entry;
    logic [DEPTH_W-1:0] depth;

    logic               q_full;
    logic               res_load;
    res_t               res;
    logic               clear;
    logic               accept;
    logic               unwind_start;
    logic               can_push;
    logic               odd;
    logic [LEVEL_W-1:0] base_lv;
    logic [LEVEL_W-1:0] cur_level;
    logic [LEVEL_W-1:0] pop_level;
    ovr_t               cur_ovr;

    // paragraph level register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_level_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            base_level_reg <= cfg_wdata;
        end
    end

    // current entry: the paragraph entry when nothing is pushed
    assign base_lv   = {{(LEVEL_W-1){1'b0}}, base_level_reg};
    assign cur_level = (depth == '0) ? base_lv : top_entry.level;
    assign cur_ovr   = (depth == '0) ? OVR_NONE : top_entry.ovr;
    assign pop_level = (depth > DEPTH_W'(1)) ? next_entry.level : base_lv;
    assign can_push  = (depth < DEPTH_W'(MAX_NESTING)) && (ovf_iso_reg == '0)
                       && (ovf_emb_reg == '0);

    assign in_ready     = (state_reg == S_IDLE) && !q_full;
    assign accept       = in_valid && in_ready;
    assign unwind_start = accept && (bidi_class == CLS_PDI) && (ovf_iso_reg == '0)
                          && (valid_iso_reg != '0);
    assign odd          = (bidi_class == CLS_RLE) || (bidi_class == CLS_RLO)
                          || (bidi_class == CLS_RLI)
                          || ((bidi_class == CLS_FSI) && fsi_is_rtl);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (unwind_start)
                begin
                    state_next = S_UNWIND;
                end
            end
            S_UNWIND:
            begin
                if (top_entry.iso || (depth == '0))
                begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (!q_full)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // per-class actions and result
    always_comb
    begin
        stk_ctl        = '0;
        push_entry     = '0;
        ovf_iso_next   = ovf_iso_reg;
        ovf_emb_next   = ovf_emb_reg;
        valid_iso_next = valid_iso_reg;
        last_hold_next = last_hold_reg;
        res_load       = 1'b0;
        res            = '0;
        clear          = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    res_load  = 1'b1;
                    res.level = cur_level;
                    res.cls   = apply_override(cur_ovr, bidi_class);
                    clear     = last_of_paragraph;
                    case (bidi_class)
                        CLS_LRE, CLS_LRO, CLS_RLE, CLS_RLO:
                        begin
                            res.cls = CLS_BN;
                            if (can_push)
                            begin
                                stk_ctl.push     = 1'b1;
                                push_entry.level = next_level(cur_level, odd);
                                push_entry.ovr   = (bidi_class == CLS_LRO) ? OVR_L :
                                                   (bidi_class == CLS_RLO) ? OVR_R : OVR_NONE;
                                push_entry.iso   = 1'b0;
                                res.level        = push_entry.level;
                            end
                            else if ((ovf_iso_reg == '0) && (ovf_emb_reg != CNT_MAX))
                            begin
                                ovf_emb_next = ovf_emb_reg + CNT_W'(1);
                            end
                        end
                        CLS_PDF:
                        begin
                            res.cls = CLS_BN;
                            if (ovf_iso_reg != '0)
                            begin
                                // inside an overflowed isolate: no effect
                            end
                            else if (ovf_emb_reg != '0)
                            begin
                                ovf_emb_next = ovf_emb_reg - CNT_W'(1);
                            end
                            else if ((depth != '0) && !top_entry.iso)
                            begin
                                stk_ctl.pop = 1'b1;
                                res.level   = pop_level;
                            end
                        end
                        CLS_LRI, CLS_RLI, CLS_FSI:
                        begin
                            if (can_push)
                            begin
                                stk_ctl.push     = 1'b1;
                                push_entry.level = next_level(cur_level, odd);
                                push_entry.ovr   = OVR_NONE;
                                push_entry.iso   = 1'b1;
                                valid_iso_next   = valid_iso_reg + DEPTH_W'(1);
                            end
                            else if (ovf_iso_reg != CNT_MAX)
                            begin
                                ovf_iso_next = ovf_iso_reg + CNT_W'(1);
                            end
                        end
                        CLS_PDI:
                        begin
                            if (ovf_iso_reg != '0)
                            begin
                                ovf_iso_next = ovf_iso_reg - CNT_W'(1);
                            end
                            else if (valid_iso_reg != '0)
                            begin
                                // matched isolate: unwind, result after the pops
                                res_load       = 1'b0;
                                clear          = 1'b0;
                                last_hold_next = last_of_paragraph;
                                ovf_emb_next   = '0;
                                valid_iso_next = valid_iso_reg - DEPTH_W'(1);
                            end
                        end
                        CLS_B:
                        begin
                            res.level = base_lv;
                            res.cls   = bidi_class;
                        end
                        CLS_BN:
                        begin
                            res.cls = bidi_class;
                        end
                        default:
                        begin
                            // neutral handling already set above
                        end
                    endcase
                end
            end
            S_UNWIND:
            begin
                stk_ctl.pop = 1'b1;
            end
            S_EMIT:
            begin
                if (!q_full)
                begin
                    res_load  = 1'b1;
                    res.level = cur_level;
                    res.cls   = apply_override(cur_ovr, CLS_PDI);
                    clear     = last_hold_reg;
                end
            end
            default:
            begin
                res_load = 1'b0;
            end
        endcase

        // end of paragraph clears the stack depth and the overflow and isolate counters
        if (clear)
        begin
            stk_ctl.clear  = 1'b1;
            ovf_iso_next   = '0;
            ovf_emb_next   = '0;
            valid_iso_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            ovf_iso_reg   <= '0;
            ovf_emb_reg   <= '0;
            valid_iso_reg <= '0;
            last_hold_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ovf_iso_reg   <= ovf_iso_next;
            ovf_emb_reg   <= ovf_emb_next;
            valid_iso_reg <= valid_iso_next;
            last_hold_reg <= last_hold_next;
        end
    end

    // status stack
    bxlr_stack u_stack (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (stk_ctl),
        .push_entry (push_entry),
        .top_entry  (top_entry),
        .next_entry (next_entry),
        .depth      (depth)
    );

    // result queue
    bxlr_outq u_outq (
        .clk            (clk),
        .rst_n          (rst_n),
        .load           (res_load),
        .load_res       (res),
        .full           (q_full),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .level          (level),
        .resolved_class (resolved_class)
    );

    // checks
    a_unwind_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_UNWIND) |-> (depth != '0))
        else $error("unwind with an empty stack");

    a_iso_count: assert property (@(posedge clk) disable iff (!rst_n)
        valid_iso_reg <= depth)
        else $error("more valid isolates than stack entries");

    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (out_valid || (state_reg == S_UNWIND)))
        else $error("accepted request left no result");

endmodule

### bench/tb_bidi_explicit_level_resolver.sv
// tb_bidi_explicit_level_resolver: self-checking bench for the explicit embedding level resolver
// depends on bxlr_pkg and bidi_explicit_level_resolver; runs directed, overflow and random tests
// against an in-bench predictor of rules X1 to X9
`timescale 1ns / 1ps

module tb_bidi_explicit_level_resolver;

    import bxlr_pkg::*;

    // class codes the package does not name
    localparam logic [CLASS_W-1:0] CLS_AL  = 5'd2;
    localparam logic [CLASS_W-1:0] CLS_EN  = 5'd3;
    localparam logic [CLASS_W-1:0] CLS_AN  = 5'd6;
    localparam logic [CLASS_W-1:0] CLS_WS  = 5'd12;
    localparam logic [CLASS_W-1:0] CLS_ON  = 5'd13;
    localparam logic [CLASS_W-1:0] CLS_TOP = 5'd31;

    localparam int MAX_GAP      = 14;
    localparam int RANDOM_ITEMS = 1150;
    localparam int OVF_EXTRA    = 12;
    localparam int CYCLE_LIMIT  = 3_000_000;
    localparam int PRINT_LIMIT  = 40;

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_ready;
    logic [CLASS_W-1:0]   bidi_class;
    logic                 fsi_is_rtl;
    logic                 last_of_paragraph;
    logic                 out_valid;
    logic                 out_ready;
    logic [LEVEL_W-1:0]   level;
    logic [CLASS_W-1:0]   resolved_class;
    logic                 cfg_we;
    logic                 cfg_wdata;

    // predicted directional status
    logic                 base_lvl;
    logic [LEVEL_W-1:0]   nest_lvl [0:MAX_NESTING];
    ovr_t                 nest_ovr [0:MAX_NESTING];
    logic                 nest_iso [0:MAX_NESTING];
    logic [DEPTH_W-1:0]   depth;
    logic [LEVEL_W-1:0]   cur_lvl;
    logic [CNT_W-1:0]     iso_ovf;
    logic [CNT_W-1:0]     emb_ovf;
    logic [DEPTH_W-1:0]   open_isolates;

    res_t                 expected_levels [$];
    res_t                 head;
    int                   mismatches;
    int                   cycles;
    logic                 calm;

    bidi_explicit_level_resolver DUT (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .bidi_class        (bidi_class),
        .fsi_is_rtl        (fsi_is_rtl),
        .last_of_paragraph (last_of_paragraph),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .level             (level),
        .resolved_class    (resolved_class),
        .cfg_we            (cfg_we),
        .cfg_wdata         (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ---------------------------------------------------------------- predictor

    // status back to the paragraph entry
    task automatic reset_paragraph();
        for (int i = 0; i <= MAX_NESTING; i++)
        begin
            nest_lvl[i] = '0;
            nest_ovr[i] = OVR_NONE;
            nest_iso[i] = 1'b0;
        end
        nest_lvl[0]   = LEVEL_W'(base_lvl);
        depth         = '0;
        cur_lvl       = LEVEL_W'(base_lvl);
        iso_ovf       = '0;
        emb_ovf       = '0;
        open_isolates = '0;
    endtask

    // least odd or even level above lv
    function automatic logic [LEVEL_W-1:0] raise_level(input logic [LEVEL_W-1:0] lv,
                                                       input logic odd);
        if (odd)
            return lv + LEVEL_W'(1) + LEVEL_W'(lv[0]);
        return lv + LEVEL_W'(2) - LEVEL_W'(lv[0]);
    endfunction

    function automatic logic room_to_push();
        return (depth < MAX_NESTING) && (iso_ovf == '0) && (emb_ovf == '0);
    endfunction

    function automatic logic [CLASS_W-1:0] overridden(input logic [CLASS_W-1:0] c);
        case (nest_ovr[depth])
            OVR_L:   return CLS_L;
            OVR_R:   return CLS_R;
            default: return c;
        endcase
    endfunction

    task automatic open_entry(input logic odd, input ovr_t o, input logic iso);
        depth           = depth + 1'b1;
        cur_lvl         = raise_level(cur_lvl, odd);
        nest_lvl[depth] = cur_lvl;
        nest_ovr[depth] = o;
        nest_iso[depth] = iso;
    endtask

    task automatic close_entry();
        if (depth > 0)
            depth = depth - 1'b1;
        cur_lvl = nest_lvl[depth];
    endtask

    // level and class of one character, status updated
    task automatic resolve_explicit(input logic [CLASS_W-1:0] c, input logic fsi_rtl,
                                    input logic last, output res_t r);
        logic odd;
        ovr_t o;
        r.level = cur_lvl;
        r.cls   = overridden(c);
        if (c >= CLS_LRE && c <= CLS_RLO)
        begin
            if (room_to_push())
            begin
                odd = (c == CLS_RLE) || (c == CLS_RLO);
                if (c == CLS_LRO)
                    o = OVR_L;
                else if (c == CLS_RLO)
                    o = OVR_R;
                else
                    o = OVR_NONE;
                open_entry(odd, o, 1'b0);
            end
            else if (iso_ovf == '0 && emb_ovf != CNT_MAX)
            begin
                emb_ovf = emb_ovf + 1'b1;
            end
            r.level = cur_lvl;
            r.cls   = CLS_BN;
        end
        else if (c == CLS_PDF)
        begin
            if (iso_ovf != '0)
            begin
                // inside an overflowed isolate nothing happens
            end
            else if (emb_ovf != '0)
                emb_ovf = emb_ovf - 1'b1;
            else if (depth > 0 && !nest_iso[depth])
                close_entry();
            r.level = cur_lvl;
            r.cls   = CLS_BN;
        end
        else if (c >= CLS_LRI && c <= CLS_FSI)
        begin
            // level and class come from before the push
            odd = (c == CLS_RLI) || (c == CLS_FSI && fsi_rtl);
            if (room_to_push())
            begin
                open_entry(odd, OVR_NONE, 1'b1);
                open_isolates = open_isolates + 1'b1;
            end
            else if (iso_ovf != CNT_MAX)
            begin
                iso_ovf = iso_ovf + 1'b1;
            end
        end
        else if (c == CLS_PDI)
        begin
            if (iso_ovf != '0)
            begin
                iso_ovf = iso_ovf - 1'b1;
            end
            else if (open_isolates != '0)
            begin
                // unwind to and through the matching isolate entry
                emb_ovf = '0;
                while (depth > 0 && !nest_iso[depth])
                    close_entry();
                close_entry();
                open_isolates = open_isolates - 1'b1;
            end
            r.level = cur_lvl;
            r.cls   = overridden(c);
        end
        else if (c == CLS_B)
        begin
            r.level = LEVEL_W'(base_lvl);
            r.cls   = c;
        end
        else if (c == CLS_BN)
        begin
            r.cls = c;
        end
        if (last)
            reset_paragraph();
    endtask

    // ---------------------------------------------------------------- driving

    // one request; valid stays high after acceptance until the next gap or a drain
    task automatic send_char(input logic [CLASS_W-1:0] c, input logic fsi_rtl,
                             input logic last);
        int   gap;
        res_t want;
        gap = calm ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid          <= 1'b1;
        bidi_class        <= c;
        fsi_is_rtl        <= fsi_rtl;
        last_of_paragraph <= last;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        resolve_explicit(c, fsi_rtl, last, want);
        expected_levels.push_back(want);
    endtask

    // hold off until every predicted result has come back
    task automatic drain_results();
        in_valid <= 1'b0;
        while (expected_levels.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_base(input logic v);
        drain_results();
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we    <= 1'b0;
        base_lvl    = v;
        nest_lvl[0] = LEVEL_W'(v);
        if (depth == '0)
            cur_lvl = LEVEL_W'(v);
    endtask

    // embedding and isolate initiators, k in 0..6
    function automatic logic [CLASS_W-1:0] push_class(input int k);
        if (k < 4)
            return CLASS_W'(CLS_LRE + k);
        return CLASS_W'(CLS_LRI + k - 4);
    endfunction

    // result side: random stall before each result
    initial
    begin
        int stall;
        out_ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            stall = calm ? 0 : $urandom_range(0, MAX_GAP);
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
        end
    end

    // ---------------------------------------------------------------- checking

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatches++;
        if (mismatches <= PRINT_LIMIT)
            $display("mismatch at %0t: %s got %0d want %0d", $time, what, got, want);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_levels.size() == 0)
            begin
                report_mismatch("result with none outstanding, level", level, 0);
            end
            else
            begin
                head = expected_levels.pop_front();
                if (level !== head.level)
                    report_mismatch("level", level, head.level);
                if (resolved_class !== head.cls)
                    report_mismatch("resolved_class", resolved_class, head.cls);
            end
        end
    end

    // run limit
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("[bidi_explicit_level_resolver] ERROR");
            $finish;
        end
    end

    // ---------------------------------------------------------------- tests

    // every control, overrides on neutrals and isolates, unmatched pops, B and BN
    task automatic test_directed_classes();
        send_char(CLS_RLO, 1'b0, 1'b0);
        send_char(CLS_L,   1'b0, 1'b0);
        send_char(CLS_ON,  1'b0, 1'b0);
        send_char(CLS_TOP, 1'b0, 1'b0);
        send_char(CLS_FSI, 1'b0, 1'b0);
        send_char(CLS_EN,  1'b0, 1'b0);
        send_char(CLS_LRO, 1'b0, 1'b0);
        send_char(CLS_AN,  1'b0, 1'b0);
        send_char(CLS_PDI, 1'b0, 1'b0);
        send_char(CLS_PDF, 1'b0, 1'b0);
        send_char(CLS_PDF, 1'b0, 1'b0);
        send_char(CLS_PDI, 1'b0, 1'b0);
        send_char(CLS_RLE, 1'b0, 1'b0);
        send_char(CLS_BN,  1'b0, 1'b0);
        send_char(CLS_B,   1'b0, 1'b0);
        send_char(CLS_LRI, 1'b0, 1'b0);
        send_char(CLS_RLI, 1'b0, 1'b0);
        send_char(CLS_FSI, 1'b1, 1'b0);
        send_char(CLS_WS,  1'b0, 1'b0);
        send_char(CLS_PDI, 1'b1, 1'b0);
        send_char(CLS_PDI + 1'b1, 1'b0, 1'b0);
        send_char(CLS_LRE, 1'b0, 1'b1);
        send_char(CLS_R,   1'b0, 1'b0);
        // right-to-left paragraph
        write_base(1'b1);
        send_char(CLS_AL,  1'b0, 1'b0);
        send_char(CLS_LRE, 1'b0, 1'b0);
        send_char(CLS_PDF, 1'b0, 1'b1);
    endtask

    // both overflow counters driven past the nesting limit, back to back
    task automatic test_overflow_counters();
        calm = 1'b1;
        write_base(1'b1);
        // embedding overflow under one valid isolate
        send_char(CLS_LRI, 1'b0, 1'b0);
        repeat (MAX_NESTING - 1)
            send_char(CLS_LRE, 1'b0, 1'b0);
        repeat (OVF_EXTRA)
            send_char(CLS_RLO, 1'b0, 1'b0);
        send_char(CLS_PDF, 1'b0, 1'b0);
        send_char(CLS_LRI, 1'b1, 1'b0);
        send_char(CLS_PDI, 1'b0, 1'b0);
        send_char(CLS_PDI, 1'b0, 1'b0);
        send_char(CLS_L,   1'b0, 1'b1);
        // isolate overflow
        repeat (MAX_NESTING)
            send_char(CLS_RLI, 1'b0, 1'b0);
        repeat (OVF_EXTRA)
            send_char(CLS_FSI, 1'($urandom_range(0, 1)), 1'b0);
        send_char(CLS_PDI, 1'b0, 1'b0);
        send_char(CLS_PDF, 1'b0, 1'b0);
        send_char(CLS_LRE, 1'b0, 1'b0);
        send_char(CLS_PDI, 1'b0, 1'b0);
        send_char(CLS_ON,  1'b0, 1'b1);
        calm = 1'b0;
    endtask

    // random paragraphs: mostly nesting traffic, some deep runs, some noise
    task automatic test_random_paragraphs(input int total);
        int                 sent;
        int                 chunk;
        int                 pick;
        logic [CLASS_W-1:0] c;
        sent = 0;
        write_base(1'b0);
        while (sent < total)
        begin
            // between chunks: new base level, plain pause, or straight on
            case ($urandom_range(0, 3))
                0:       write_base(1'($urandom_range(0, 1)));
                1:       drain_results();
                default: ;
            endcase
            calm = ($urandom_range(0, 3) == 0);
            // now and then a deep push run, at times past the nesting limit
            if ($urandom_range(0, 5) == 0)
            begin
                chunk = $urandom_range(110, 140);
                repeat (chunk)
                    send_char(push_class($urandom_range(0, 6)),
                              1'($urandom_range(0, 1)), 1'b0);
                sent += chunk;
            end
            chunk = $urandom_range(20, 120);
            repeat (chunk)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 30)
                    c = push_class($urandom_range(0, 6));
                else if (pick < 45)
                    c = CLS_PDF;
                else if (pick < 58)
                    c = CLS_PDI;
                else if (pick < 90)
                    c = CLASS_W'($urandom_range(CLS_L, CLS_ON));
                else if (pick < 95)
                    c = ($urandom_range(0, 1) == 0) ? CLS_BN : CLS_B;
                else
                    c = CLASS_W'($urandom_range(CLS_PDI + 1, CLS_TOP));
                send_char(c, 1'($urandom_range(0, 1)), ($urandom_range(0, 39) == 0));
            end
            sent += chunk;
        end
        calm = 1'b0;
    endtask

    // ---------------------------------------------------------------- sequence

    initial
    begin
        rst_n             = 1'b0;
        in_valid          = 1'b0;
        bidi_class        = CLS_L;
        fsi_is_rtl        = 1'b0;
        last_of_paragraph = 1'b0;
        cfg_we            = 1'b0;
        cfg_wdata         = 1'b0;
        calm              = 1'b0;
        mismatches        = 0;
        cycles            = 0;
        base_lvl          = 1'b0;
        reset_paragraph();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_classes();
        test_overflow_counters();
        test_random_paragraphs(RANDOM_ITEMS);

        drain_results();
        repeat (150) @(posedge clk);
        if (mismatches == 0)
            $display("[bidi_explicit_level_resolver] OK");
        else
            $display("[bidi_explicit_level_resolver] ERROR");
        $finish;
    end

endmodule

### files.f
rtl/core/bxlr_pkg.sv
rtl/core/bxlr_cell.sv
rtl/core/bxlr_stack.sv
rtl/core/bxlr_outq.sv
rtl/core/bidi_explicit_level_resolver.sv
bench/tb_bidi_explicit_level_resolver.sv
